### hw/rtl/ffha_pkg.sv
// shared types and constants for the first-fit heap allocator
// no dependencies; used by every module of the block

package ffha_pkg;

  // heap geometry
  localparam int GRANULE_BYTES    = 64;
  localparam int GRANULE_LOG2     = 6;
  localparam int HEAP_GRANULES    = 1024;
  localparam int HEADER_BYTES     = 24;
  localparam int MAX_FREE_EXTENTS = 64;

  // derived widths
  localparam int GW     = 10;  // granule index
  localparam int LW     = 11;  // length in granules
  localparam int XW     = 6;   // extent table index
  localparam int CW     = 7;   // extent count
  localparam int NEED_W = 12;  // rounded request size
  localparam int OFF_W  = 16;
  localparam int REQ_W  = 17;
  localparam int ST_W   = 3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [ST_W-1:0] ST_NOFIT   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_BADFREE = 3'd4;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic [GW-1:0] start;
    logic [LW-1:0] len;
  } ext_t;

  typedef struct packed {
    logic          we;
    logic [XW-1:0] waddr;
    ext_t          wdata;
    logic [XW-1:0] raddr;
  } ext_req_t;

  typedef struct packed {
    logic          we;
    logic [GW-1:0] waddr;
    logic [LW-1:0] wdata;
    logic [GW-1:0] raddr;
  } len_req_t;

endpackage

### hw/rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator with coalescing over a 1024-granule, 64-byte-granule
// heap. One command is in flight at a time; an allocate scans the extent table
// and shifts the entries above an extent that is used up exactly; a free reads
// the granted length, scans the extent table and shifts entries on a merge of
// both sides or when a new extent is opened, all through the single-port walk
// over the extent table. A new command is taken while the previous result waits
// at the output. After reset the granted-length store is cleared, one granule
// per cycle, and in_tready stays low until the clear is done.
// depends on ffha_pkg, ffha_ext_ram, ffha_len_ram, ffha_ctrl

module first_fit_heap_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // request_bytes[16:0], release_offset[32:17], zero fill
  input  logic [0:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // granted_offset[15:0], status[18:16], zero fill
);

  ffha_pkg::ext_req_t              ext_req;
  ffha_pkg::ext_t                  ext_rd;
  ffha_pkg::len_req_t              len_req;
  logic [ffha_pkg::LW-1:0]         len_rd;
  logic [ffha_pkg::OFF_W-1:0]      out_off;
  logic [ffha_pkg::ST_W-1:0]       out_status;

  // extent table
  ffha_ext_ram u_ext (
    .clk   (clk),
    .req   (ext_req),
    .rdata (ext_rd)
  );

  // granted length per granule
  ffha_len_ram u_len (
    .clk   (clk),
    .req   (len_req),
    .rdata (len_rd)
  );

  // sequencer
  ffha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser[0]),
    .in_bytes   (in_tdata[16:0]),
    .in_off     (in_tdata[32:17]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_off    (out_off),
    .out_status (out_status),
    .ext_req    (ext_req),
    .ext_rd     (ext_rd),
    .len_req    (len_req),
    .len_rd     (len_rd)
  );

  // result packing
  assign out_tdata = {5'b0, out_status, out_off};

`ifndef NO_ASSERTIONS
  // one command at a time: busy right after a transfer in
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // no memory writes while waiting for a command
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !ext_req.we && !len_req.we)
    else $error("memory write while idle");

  // status code in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_status <= ffha_pkg::ST_BADFREE)
    else $error("status out of range");

  // errors carry a zero offset
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status != ffha_pkg::ST_OK) |-> out_off == '0)
    else $error("nonzero offset on error");
`endif

endmodule

### hw/rtl/ffha_ext_ram.sv
// free extent table: one write and one registered read port
// depends on ffha_pkg

module ffha_ext_ram (
  input  logic              clk,
  input  ffha_pkg::ext_req_t req,
  output ffha_pkg::ext_t    rdata
);

  ffha_pkg::ext_t mem [ffha_pkg::MAX_FREE_EXTENTS];

  // write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

### hw/rtl/ffha_len_ram.sv
// per-granule granted length store: one write and one registered read port
// depends on ffha_pkg

module ffha_len_ram (
  input  logic                         clk,
  input  ffha_pkg::len_req_t           req,
  output logic [ffha_pkg::LW-1:0]      rdata
);

  logic [ffha_pkg::LW-1:0] mem [ffha_pkg::HEAP_GRANULES];

  // write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

### hw/rtl/ffha_ctrl.sv
// sequencer for the allocator: table scans, shifts, merges and result register
// depends on ffha_pkg; drives both memories through request structs

module ffha_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic                         in_cmd,
  input  logic [ffha_pkg::REQ_W-1:0]   in_bytes,
  input  logic [ffha_pkg::OFF_W-1:0]   in_off,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ffha_pkg::OFF_W-1:0]   out_off,
  output logic [ffha_pkg::ST_W-1:0]    out_status,
  output ffha_pkg::ext_req_t           ext_req,
  input  ffha_pkg::ext_t               ext_rd,
  output ffha_pkg::len_req_t           len_req,
  input  logic [ffha_pkg::LW-1:0]      len_rd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ASCAN, S_FLEN, S_FSCAN, S_MERGE, S_DROP, S_INS, S_DONE
  } state_t;

  localparam int SUM_W = ffha_pkg::REQ_W + 1;
  localparam int CALC_W = 32;

  state_t                       state_r, state_nxt;
  logic [ffha_pkg::GW-1:0]      clr_r, clr_nxt;
  logic [ffha_pkg::CW-1:0]      cnt_r, cnt_nxt;
  logic [ffha_pkg::CW-1:0]      k_r, k_nxt;
  logic [ffha_pkg::CW-1:0]      ridx_r, ridx_nxt;
  logic                         rdv_r, rdv_nxt;
  logic [ffha_pkg::CW-1:0]      pos_r, pos_nxt;
  logic [ffha_pkg::NEED_W-1:0]  need_r, need_nxt;
  logic [ffha_pkg::GW-1:0]      g_r, g_nxt;
  logic [ffha_pkg::LW-1:0]      glen_r, glen_nxt;
  ffha_pkg::ext_t               prev_r, prev_nxt;
  ffha_pkg::ext_t               next_r, next_nxt;
  logic                         hnext_r, hnext_nxt;
  logic [ffha_pkg::OFF_W-1:0]   res_off_r, res_off_nxt;
  logic [ffha_pkg::ST_W-1:0]    res_st_r, res_st_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [ffha_pkg::OFF_W-1:0]   out_off_r, out_off_nxt;
  logic [ffha_pkg::ST_W-1:0]    out_st_r, out_st_nxt;

  // request size in granules, header included
  logic [SUM_W-1:0]             sum_w;
  logic [ffha_pkg::NEED_W-1:0]  need_w;
  // free offset decode
  logic [ffha_pkg::OFF_W-1:0]   rel_w;
  logic [ffha_pkg::OFF_W-1:0]   gfull_w;
  logic                         bad_w;
  // merge decisions
  logic [ffha_pkg::NEED_W-1:0]  prev_end_w, blk_end_w;
  logic                         jp_w, jn_w;

  assign sum_w  = {1'b0, in_bytes}
                + SUM_W'(ffha_pkg::HEADER_BYTES + ffha_pkg::GRANULE_BYTES - 1);
  assign need_w = ffha_pkg::NEED_W'(sum_w >> ffha_pkg::GRANULE_LOG2);

  assign rel_w   = in_off - ffha_pkg::OFF_W'(ffha_pkg::HEADER_BYTES);
  assign gfull_w = rel_w >> ffha_pkg::GRANULE_LOG2;
  assign bad_w   = (in_off < ffha_pkg::OFF_W'(ffha_pkg::HEADER_BYTES))
                || (rel_w[ffha_pkg::GRANULE_LOG2-1:0] != '0)
                || (CALC_W'(gfull_w) >= CALC_W'(ffha_pkg::HEAP_GRANULES));

  assign prev_end_w = ffha_pkg::NEED_W'(prev_r.start) + ffha_pkg::NEED_W'(prev_r.len);
  assign blk_end_w  = ffha_pkg::NEED_W'(g_r) + ffha_pkg::NEED_W'(glen_r);
  assign jp_w = (pos_r != '0) && (prev_end_w == ffha_pkg::NEED_W'(g_r));
  assign jn_w = hnext_r && (blk_end_w == ffha_pkg::NEED_W'(next_r.start));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_off    = out_off_r;
  assign out_status = out_st_r;

  // next-state and memory request logic
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    ridx_nxt    = ridx_r;
    rdv_nxt     = rdv_r;
    pos_nxt     = pos_r;
    need_nxt    = need_r;
    g_nxt       = g_r;
    glen_nxt    = glen_r;
    prev_nxt    = prev_r;
    next_nxt    = next_r;
    hnext_nxt   = hnext_r;
    res_off_nxt = res_off_r;
    res_st_nxt  = res_st_r;
    out_valid_nxt = out_valid_r;
    out_off_nxt = out_off_r;
    out_st_nxt  = out_st_r;
    ext_req     = '0;
    len_req     = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // clear the length store, seed the extent table
      S_INIT: begin
        len_req.we      = 1'b1;
        len_req.waddr   = clr_r;
        ext_req.we      = 1'b1;
        ext_req.waddr   = '0;
        ext_req.wdata.start = '0;
        ext_req.wdata.len   = ffha_pkg::LW'(ffha_pkg::HEAP_GRANULES);
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ffha_pkg::GW'(ffha_pkg::HEAP_GRANULES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      // take a command
      S_IDLE: begin
        k_nxt       = '0;
        rdv_nxt     = 1'b0;
        hnext_nxt   = 1'b0;
        res_off_nxt = '0;
        if (in_tvalid) begin
          if (in_cmd == ffha_pkg::CMD_ALLOC) begin
            need_nxt = need_w;
            if (in_bytes == '0) begin
              res_st_nxt = ffha_pkg::ST_ZERO;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_ASCAN;
            end
          end else begin
            g_nxt         = ffha_pkg::GW'(gfull_w);
            len_req.raddr = ffha_pkg::GW'(gfull_w);
            if (bad_w) begin
              res_st_nxt = ffha_pkg::ST_BADFREE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FLEN;
            end
          end
        end
      end
      // first-fit search, one entry per cycle
      S_ASCAN: begin
        if (rdv_r && (ffha_pkg::NEED_W'(ext_rd.len) >= need_r)) begin
          len_req.we    = 1'b1;
          len_req.waddr = ext_rd.start;
          len_req.wdata = ffha_pkg::LW'(need_r);
          res_off_nxt   = ffha_pkg::OFF_W'(CALC_W'(ext_rd.start) * ffha_pkg::GRANULE_BYTES
                                         + ffha_pkg::HEADER_BYTES);
          res_st_nxt    = ffha_pkg::ST_OK;
          rdv_nxt       = 1'b0;
          if (ffha_pkg::NEED_W'(ext_rd.len) == need_r) begin
            k_nxt     = ridx_r + 1'b1;
            state_nxt = S_DROP;
          end else begin
            ext_req.we          = 1'b1;
            ext_req.waddr       = ridx_r[ffha_pkg::XW-1:0];
            ext_req.wdata.start = ext_rd.start + ffha_pkg::GW'(need_r);
            ext_req.wdata.len   = ext_rd.len - ffha_pkg::LW'(need_r);
            state_nxt           = S_DONE;
          end
        end else if (k_r < cnt_r) begin
          ext_req.raddr = k_r[ffha_pkg::XW-1:0];
          ridx_nxt      = k_r;
          rdv_nxt       = 1'b1;
          k_nxt         = k_r + 1'b1;
        end else begin
          res_st_nxt = ffha_pkg::ST_NOFIT;
          state_nxt  = S_DONE;
        end
      end
      // granted length of the block being freed
      S_FLEN: begin
        glen_nxt = len_rd;
        if (len_rd == '0) begin
          res_st_nxt = ffha_pkg::ST_BADFREE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_FSCAN;
        end
      end
      // find the first extent above the block
      S_FSCAN: begin
        if (rdv_r && (ext_rd.start > g_r)) begin
          pos_nxt   = ridx_r;
          next_nxt  = ext_rd;
          hnext_nxt = 1'b1;
          rdv_nxt   = 1'b0;
          state_nxt = S_MERGE;
        end else begin
          if (rdv_r) begin
            prev_nxt = ext_rd;
          end
          if (k_r < cnt_r) begin
            ext_req.raddr = k_r[ffha_pkg::XW-1:0];
            ridx_nxt      = k_r;
            rdv_nxt       = 1'b1;
            k_nxt         = k_r + 1'b1;
          end else begin
            pos_nxt   = cnt_r;
            rdv_nxt   = 1'b0;
            state_nxt = S_MERGE;
          end
        end
      end
      // coalesce with neighbors or open a new extent
      S_MERGE: begin
        res_st_nxt = ffha_pkg::ST_OK;
        if (jp_w || jn_w || (cnt_r < ffha_pkg::CW'(ffha_pkg::MAX_FREE_EXTENTS))) begin
          len_req.we    = 1'b1;
          len_req.waddr = g_r;
          len_req.wdata = '0;
        end
        if (jp_w && jn_w) begin
          ext_req.we          = 1'b1;
          ext_req.waddr       = ffha_pkg::XW'(pos_r - 1'b1);
          ext_req.wdata.start = prev_r.start;
          ext_req.wdata.len   = prev_r.len + glen_r + next_r.len;
          k_nxt               = pos_r + 1'b1;
          state_nxt           = S_DROP;
        end else if (jp_w) begin
          ext_req.we          = 1'b1;
          ext_req.waddr       = ffha_pkg::XW'(pos_r - 1'b1);
          ext_req.wdata.start = prev_r.start;
          ext_req.wdata.len   = prev_r.len + glen_r;
          state_nxt           = S_DONE;
        end else if (jn_w) begin
          ext_req.we          = 1'b1;
          ext_req.waddr       = pos_r[ffha_pkg::XW-1:0];
          ext_req.wdata.start = g_r;
          ext_req.wdata.len   = next_r.len + glen_r;
          state_nxt           = S_DONE;
        end else if (cnt_r >= ffha_pkg::CW'(ffha_pkg::MAX_FREE_EXTENTS)) begin
          res_st_nxt = ffha_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          k_nxt     = cnt_r;
          state_nxt = S_INS;
        end
      end
      // shift entries down over a removed extent
      S_DROP: begin
        if (rdv_r) begin
          ext_req.we    = 1'b1;
          ext_req.waddr = ffha_pkg::XW'(ridx_r - 1'b1);
          ext_req.wdata = ext_rd;
        end
        if (k_r < cnt_r) begin
          ext_req.raddr = k_r[ffha_pkg::XW-1:0];
          ridx_nxt      = k_r;
          rdv_nxt       = 1'b1;
          k_nxt         = k_r + 1'b1;
        end else begin
          rdv_nxt = 1'b0;
          if (!rdv_r) begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      // shift entries up to open a slot, then fill it
      S_INS: begin
        if (rdv_r) begin
          ext_req.we    = 1'b1;
          ext_req.waddr = ffha_pkg::XW'(ridx_r + 1'b1);
          ext_req.wdata = ext_rd;
        end
        if (k_r > pos_r) begin
          ext_req.raddr = ffha_pkg::XW'(k_r - 1'b1);
          ridx_nxt      = k_r - 1'b1;
          rdv_nxt       = 1'b1;
          k_nxt         = k_r - 1'b1;
        end else begin
          rdv_nxt = 1'b0;
          if (!rdv_r) begin
            ext_req.we          = 1'b1;
            ext_req.waddr       = pos_r[ffha_pkg::XW-1:0];
            ext_req.wdata.start = g_r;
            ext_req.wdata.len   = glen_r;
            cnt_nxt             = cnt_r + 1'b1;
            state_nxt           = S_DONE;
          end
        end
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_off_nxt   = (res_st_r == ffha_pkg::ST_OK) ? res_off_r : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      cnt_r       <= ffha_pkg::CW'(1);
      k_r         <= '0;
      rdv_r       <= 1'b0;
      hnext_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      rdv_r       <= rdv_nxt;
      hnext_r     <= hnext_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ridx_r    <= ridx_nxt;
    pos_r     <= pos_nxt;
    need_r    <= need_nxt;
    g_r       <= g_nxt;
    glen_r    <= glen_nxt;
    prev_r    <= prev_nxt;
    next_r    <= next_nxt;
    res_off_r <= res_off_nxt;
    res_st_r  <= res_st_nxt;
    out_off_r <= out_off_nxt;
    out_st_r  <= out_st_nxt;
  end

endmodule
